[rtl/kclc_pkg.sv]
// Package for the keypad code lock controller.
// Holds the channel item types, key, mode and status codes, and the reset code helper.
// No dependencies.
`default_nettype none

package kclc_pkg;

    localparam int CODE_DIGITS_DEF  = 4;
    localparam int OPEN_TICKS_W     = 16;
    localparam logic [OPEN_TICKS_W-1:0] OPEN_TICKS_RST = 16'd8250;

    localparam logic FUNC_KEY  = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    localparam logic [3:0] KEY_STAR = 4'd14;
    localparam logic [3:0] KEY_HASH = 4'd15;

    localparam logic [1:0] MODE_LOCKED = 2'd0;
    localparam logic [1:0] MODE_VERIFY = 2'd1;
    localparam logic [1:0] MODE_NEW    = 2'd2;
    localparam logic [1:0] MODE_OPEN   = 2'd3;

    localparam logic [3:0] ST_NONE      = 4'd0;
    localparam logic [3:0] ST_DIGIT     = 4'd1;
    localparam logic [3:0] ST_CLEARED   = 4'd2;
    localparam logic [3:0] ST_GRANTED   = 4'd3;
    localparam logic [3:0] ST_WRONG     = 4'd4;
    localparam logic [3:0] ST_CHG_START = 4'd5;
    localparam logic [3:0] ST_VERIFIED  = 4'd6;
    localparam logic [3:0] ST_CHANGED   = 4'd7;
    localparam logic [3:0] ST_CANCELLED = 4'd8;
    localparam logic [3:0] ST_CLOSED    = 4'd9;

    typedef struct packed {
        logic       func;
        logic [3:0] key_code;
    } t_in_item;

    typedef struct packed {
        logic       door_open;
        logic [3:0] status;
        logic [2:0] digits_entered;
        logic [1:0] lock_mode;
    } t_out_item;

    // Default code: nibbles 1, 2 and so on up to digits, with the first key in the highest used nibble.
    function automatic logic [31:0] reset_code(input int digits);
        logic [31:0] code;
        code = '0;
        for (int i = 1; i <= 8; i++) begin
            if (i <= digits) begin
                code = {code[27:0], 4'(i)};
            end
        end
        return code;
    endfunction

endpackage

`default_nettype wire

[rtl/kclc_if.sv]
// Valid/ready channel interface for the keypad code lock controller.
// The payload type is a parameter; depends on nothing else.
`default_nettype none

interface kclc_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/keypad_code_lock_controller.sv]
// Keypad code lock controller, top level.
// Uses kclc_pkg, kclc_if, kclc_reg_slice and kclc_lock_fsm.
//
// i_in carries one item per transfer: a key press (func 0, key_code) or a
// time tick (func 1). o_out returns exactly one result per item: door_open,
// status, digits_entered and lock_mode. i_cfg writes open_ticks; it is always
// ready, and the user must write it only while the block is idle; the block
// does not enforce this. An item passes an input register, then the lock logic
// updates its state and loads the output register in the same cycle, so a
// result reaches o_out through the input and then the output register. While
// the receiver does not stall, one item per cycle is sustained; the single
// state update per item sets that figure. While the receiver stalls, the
// output register holds its result, the input register fills with the next
// item, and then i_in.ready drops. Reset restores code 1234, an empty entry,
// locked mode, a zero timer and open_ticks 8250, and empties both registers.
`default_nettype none

module keypad_code_lock_controller #(
    parameter int CODE_DIGITS = kclc_pkg::CODE_DIGITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    kclc_if.sink      i_in,
    kclc_if.source    o_out,
    kclc_if.sink      i_cfg
);

    logic                in_valid;
    logic                res_ready;
    logic                fire;
    kclc_pkg::t_in_item  in_item;
    kclc_pkg::t_out_item result;

    kclc_reg_slice #(.T(kclc_pkg::t_in_item)) u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_data  (i_in.data),
        .o_valid (in_valid),
        .i_ready (res_ready),
        .o_data  (in_item)
    );

    assign fire = in_valid && res_ready;

    kclc_lock_fsm #(.CODE_DIGITS(CODE_DIGITS)) u_fsm (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_item     (in_item),
        .i_cfg_we   (i_cfg.valid),
        .i_cfg_data (i_cfg.data),
        .o_result   (result)
    );

    assign i_cfg.ready = 1'b1;

    kclc_reg_slice #(.T(kclc_pkg::t_out_item)) u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_valid),
        .o_ready (res_ready),
        .i_data  (result),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_data  (o_out.data)
    );

endmodule

`default_nettype wire

[rtl/kclc_reg_slice.sv]
// One register stage of a valid/ready channel that holds a single transfer.
// Depends on nothing; the payload type is a parameter.
`default_nettype none

module kclc_reg_slice #(
    parameter type T = logic
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire T     i_data,
    output logic      o_valid,
    input  wire logic i_ready,
    output T          o_data
);

    logic r_valid;
    T     r_data;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= i_data;
        end
    end

endmodule

`default_nettype wire

[rtl/kclc_lock_fsm.sv]
// Lock state: stored code, entry buffer, digit count, mode, open timer and open_ticks.
// Computes one result per processed item. Depends on kclc_pkg.
`default_nettype none

module kclc_lock_fsm #(
    parameter int CODE_DIGITS = kclc_pkg::CODE_DIGITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_fire,
    input  wire kclc_pkg::t_in_item              i_item,
    input  wire logic                            i_cfg_we,
    input  wire logic [kclc_pkg::OPEN_TICKS_W-1:0] i_cfg_data,
    output kclc_pkg::t_out_item                  o_result
);

    localparam int EW = 4 * CODE_DIGITS;
    localparam int TW = kclc_pkg::OPEN_TICKS_W;

    logic [EW-1:0] r_code,  n_code;
    logic [EW-1:0] r_entry, n_entry;
    logic [2:0]    r_count, n_count;
    logic [1:0]    r_mode,  n_mode;
    logic [TW-1:0] r_timer, n_timer;
    logic [TW-1:0] r_open_ticks;
    logic [3:0]    status;
    logic [EW-1:0] shifted;
    logic          full;

    assign shifted = EW'({r_entry, i_item.key_code});
    assign full    = ({1'b0, r_count} + 4'd1) == 4'(CODE_DIGITS);

    always_comb begin
        n_code  = r_code;
        n_entry = r_entry;
        n_count = r_count;
        n_mode  = r_mode;
        n_timer = r_timer;
        status  = kclc_pkg::ST_NONE;
        if (i_item.func == kclc_pkg::FUNC_TICK) begin
            if (r_mode == kclc_pkg::MODE_OPEN) begin
                if (r_timer <= TW'(1)) begin
                    n_timer = '0;
                    n_mode  = kclc_pkg::MODE_LOCKED;
                    status  = kclc_pkg::ST_CLOSED;
                end else begin
                    n_timer = r_timer - TW'(1);
                end
            end
        end else if (r_mode == kclc_pkg::MODE_OPEN) begin
            if (i_item.key_code == kclc_pkg::KEY_HASH) begin
                n_timer = '0;
                n_mode  = kclc_pkg::MODE_LOCKED;
                status  = kclc_pkg::ST_CLOSED;
            end
        end else if (i_item.key_code == kclc_pkg::KEY_HASH) begin
            n_entry = '0;
            n_count = '0;
            if (r_mode == kclc_pkg::MODE_LOCKED) begin
                status = kclc_pkg::ST_CLEARED;
            end else begin
                n_mode = kclc_pkg::MODE_LOCKED;
                status = kclc_pkg::ST_CANCELLED;
            end
        end else if (i_item.key_code == kclc_pkg::KEY_STAR) begin
            if (r_mode == kclc_pkg::MODE_LOCKED) begin
                n_entry = '0;
                n_count = '0;
                n_mode  = kclc_pkg::MODE_VERIFY;
                status  = kclc_pkg::ST_CHG_START;
            end
        end else if (!full) begin
            n_entry = shifted;
            n_count = r_count + 3'd1;
            status  = kclc_pkg::ST_DIGIT;
        end else begin
            n_entry = '0;
            n_count = '0;
            case (r_mode)
                kclc_pkg::MODE_LOCKED: begin
                    if (shifted == r_code) begin
                        n_mode  = kclc_pkg::MODE_OPEN;
                        n_timer = r_open_ticks;
                        status  = kclc_pkg::ST_GRANTED;
                    end else begin
                        status = kclc_pkg::ST_WRONG;
                    end
                end
                kclc_pkg::MODE_VERIFY: begin
                    if (shifted == r_code) begin
                        n_mode = kclc_pkg::MODE_NEW;
                        status = kclc_pkg::ST_VERIFIED;
                    end else begin
                        n_mode = kclc_pkg::MODE_LOCKED;
                        status = kclc_pkg::ST_WRONG;
                    end
                end
                default: begin
                    n_code = shifted;
                    n_mode = kclc_pkg::MODE_LOCKED;
                    status = kclc_pkg::ST_CHANGED;
                end
            endcase
        end
    end

    assign o_result.door_open      = (n_mode == kclc_pkg::MODE_OPEN);
    assign o_result.status         = status;
    assign o_result.digits_entered = n_count;
    assign o_result.lock_mode      = n_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code  <= EW'(kclc_pkg::reset_code(CODE_DIGITS));
            r_entry <= '0;
            r_count <= '0;
            r_mode  <= kclc_pkg::MODE_LOCKED;
            r_timer <= '0;
        end else if (i_fire) begin
            r_code  <= n_code;
            r_entry <= n_entry;
            r_count <= n_count;
            r_mode  <= n_mode;
            r_timer <= n_timer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open_ticks <= kclc_pkg::OPEN_TICKS_RST;
        end else if (i_cfg_we) begin
            r_open_ticks <= i_cfg_data;
        end
    end

endmodule

`default_nettype wire

[rtl/kclc_checker.sv]
// Port-level checks for the keypad code lock controller, bound to the top level.
// Depends on kclc_pkg and keypad_code_lock_controller.
`default_nettype none

module kclc_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_out_valid,
    input wire logic                i_out_ready,
    input wire kclc_pkg::t_out_item i_out_data
);

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("stalled result changed");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_data.door_open == (i_out_data.lock_mode == kclc_pkg::MODE_OPEN))
        else $error("door_open disagrees with lock_mode");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.status == kclc_pkg::ST_GRANTED
        |-> i_out_data.lock_mode == kclc_pkg::MODE_OPEN && i_out_data.digits_entered == 3'd0)
        else $error("grant without open door or with entry left");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.status == kclc_pkg::ST_CLOSED
        |-> i_out_data.lock_mode == kclc_pkg::MODE_LOCKED && !i_out_data.door_open)
        else $error("close did not lock");

endmodule

bind keypad_code_lock_controller kclc_checker u_kclc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);

`default_nettype wire
